FILE: rtl/core/gimr_pkg.sv
package gimr_pkg;

	localparam int EXT_W = 11;
	localparam int X_W   = 32;
	localparam int OFF_W = 31;
	localparam int MAG_W = 31;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_INC  = 3'd2,
		OP_DEC  = 3'd3,
		OP_CMP  = 3'd4
	} op_t;

	typedef enum logic {
		REG_Y_EXTENT = 1'b0,
		REG_Z_EXTENT = 1'b1
	} reg_idx_t;

	// Per-item control and position carried down the divider pipeline.
	typedef struct packed {
		logic [X_W-1:0]   x;
		logic [EXT_W-1:0] y;
		logic [EXT_W-1:0] z;
		logic             fwd;
		logic             move;
		logic             gt;
	} item_t;

	typedef struct packed {
		item_t            it;
		logic [EXT_W-1:0] zd;
	} mid_t;

endpackage

FILE: rtl/core/gimr_front.sv
module gimr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2:0]              operation,
	input  logic [31:0]             pos_x,
	input  logic [10:0]             pos_y,
	input  logic [10:0]             pos_z,
	input  logic [30:0]             offset,
	input  logic [31:0]             other_x,
	input  logic [10:0]             other_y,
	input  logic [10:0]             other_z,
	input  logic [gimr_pkg::EXT_W-1:0] y_ext,
	input  logic [gimr_pkg::EXT_W-1:0] z_ext,
	output logic                    valid_s1,
	output logic [gimr_pkg::MAG_W-1:0] mag_s1,
	output gimr_pkg::item_t         item_s1
);
	import gimr_pkg::*;

	logic              neg;
	logic [MAG_W-1:0]  mag;
	logic [EXT_W-1:0]  cy;
	logic [EXT_W-1:0]  cz;
	logic              gt;
	item_t             it;

	always_comb begin
		neg = offset[OFF_W-1];
		// Magnitude of a 31-bit two's complement value; the most negative gives 2^30.
		mag = neg ? (MAG_W'(32'h8000_0000 - {1'b0, offset})) : MAG_W'(offset);
		cy = (pos_y == '0) ? EXT_W'(1) : ((pos_y > y_ext) ? y_ext : pos_y);
		cz = (pos_z == '0) ? EXT_W'(1) : ((pos_z > z_ext) ? z_ext : pos_z);
		gt = ($signed(pos_x) > $signed(other_x)) ||
			((pos_x == other_x) && (pos_y > other_y)) ||
			((pos_x == other_x) && (pos_y == other_y) && (pos_z > other_z));
		it.x    = pos_x;
		it.y    = pos_y;
		it.z    = pos_z;
		it.fwd  = 1'b0;
		it.move = 1'b0;
		it.gt   = 1'b0;
		case (operation)
			OP_ADD: begin
				it.move = 1'b1; it.fwd = !neg; it.y = cy; it.z = cz;
			end
			OP_SUB: begin
				it.move = 1'b1; it.fwd = neg; it.y = cy; it.z = cz;
			end
			OP_INC: begin
				it.move = 1'b1; it.fwd = 1'b1; it.y = cy; it.z = cz;
				mag = MAG_W'(1);
			end
			OP_DEC: begin
				it.move = 1'b1; it.fwd = 1'b0; it.y = cy; it.z = cz;
				mag = MAG_W'(1);
			end
			OP_CMP: begin
				it.gt = gt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			item_s1 <= it;
		end
	end

endmodule

FILE: rtl/core/gimr_div.sv
module gimr_div #(
	parameter int DW = 31,
	parameter int SW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [DW-1:0]                 dividend,
	input  logic [gimr_pkg::EXT_W-1:0]    divisor,
	input  logic [SW-1:0]                 side_in,
	output logic                          out_valid,
	output logic [DW-1:0]                 quotient,
	output logic [gimr_pkg::EXT_W-1:0]    remainder,
	output logic [SW-1:0]                 side_out
);
	import gimr_pkg::*;

	// One quotient bit per stage, most significant first.
	logic                vld_s  [0:DW];
	logic [EXT_W-1:0]    rem_s  [0:DW];
	logic [DW-1:0]       dq_s   [0:DW];
	logic [SW-1:0]       side_s [0:DW];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign dq_s[0]   = dividend;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [EXT_W:0]   shifted;
		logic             ge;
		logic [EXT_W-1:0] nrem;

		always_comb begin
			shifted = {rem_s[k], dq_s[k][DW-1]};
			ge      = shifted >= {1'b0, divisor};
			nrem    = ge ? EXT_W'(shifted - {1'b0, divisor}) : EXT_W'(shifted);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= nrem;
				dq_s[k+1]   <= {dq_s[k][DW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[DW];
	assign quotient  = dq_s[DW];
	assign remainder = rem_s[DW];
	assign side_out  = side_s[DW];

endmodule

FILE: rtl/core/gimr_back.sv
module gimr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  gimr_pkg::mid_t             mid,
	input  logic [gimr_pkg::MAG_W-1:0] qx,
	input  logic [gimr_pkg::EXT_W-1:0] yd,
	input  logic [gimr_pkg::EXT_W-1:0] y_ext,
	input  logic [gimr_pkg::EXT_W-1:0] z_ext,
	output logic                       out_valid_q,
	output logic [31:0]                new_x_q,
	output logic [10:0]                new_y_q,
	output logic [10:0]                new_z_q,
	output logic                       gt_q
);
	import gimr_pkg::*;

	localparam int SW = EXT_W + 2;

	logic signed [SW-1:0] zs;
	logic signed [SW-1:0] ys;
	logic [X_W-1:0]       xs;
	logic [X_W-1:0]       nx;
	logic [EXT_W-1:0]     ny;
	logic [EXT_W-1:0]     nz;

	always_comb begin
		xs = mid.it.x;
		if (mid.it.fwd) begin
			xs = mid.it.x + X_W'(qx);
			zs = SW'(mid.it.z) + SW'(mid.zd);
			ys = SW'(mid.it.y) + SW'(yd);
			if (zs > SW'(z_ext)) begin
				zs = zs - SW'(z_ext);
				ys = ys + SW'(1);
			end
			if (ys > SW'(y_ext)) begin
				ys = ys - SW'(y_ext);
				xs = xs + X_W'(1);
			end
		end else begin
			xs = mid.it.x - X_W'(qx);
			zs = SW'(mid.it.z) - SW'(mid.zd);
			ys = SW'(mid.it.y) - SW'(yd);
			if (zs < SW'(1)) begin
				zs = zs + SW'(z_ext);
				ys = ys - SW'(1);
			end
			if (ys < SW'(1)) begin
				ys = ys + SW'(y_ext);
				xs = xs - X_W'(1);
			end
		end
		if (mid.it.move) begin
			nx = xs;
			ny = EXT_W'(ys);
			nz = EXT_W'(zs);
		end else begin
			nx = mid.it.x;
			ny = mid.it.y;
			nz = mid.it.z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_x_q <= nx;
			new_y_q <= ny;
			new_z_q <= nz;
			gt_q    <= mid.it.gt;
		end
	end

endmodule

FILE: rtl/core/grid_index_mixed_radix_step_core.sv
// Mixed-radix position counter for a one-based 3D grid scanned with z fastest,
// then y, then x. Each request carries an operation and a position; the block
// returns one result per request, in order. It accepts one request every clock
// cycle while the output is not stalled. A request passes through 64 register
// stages: one decode stage, two 31-stage dividers that retire one quotient bit
// per stage (first by the z extent, then by the y extent), and one carry/borrow
// output stage. The edge that accepts a request loads the decode stage, and the
// result is presented on m_tvalid from the output stage register.
// When the output is stalled, the whole pipeline holds, so s_tready follows
// !m_tvalid || m_tready. The y and z extents are written through the
// configuration channel, which is always ready; they must only be changed while
// no request is in flight. Extents below two act as two and extents above
// MAX_EXTENT act as MAX_EXTENT.
module grid_index_mixed_radix_step_core #(
	parameter int MAX_EXTENT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[2:0], pos_x[34:3], pos_y[45:35], pos_z[56:46], offset[87:57],
	// other_x[119:88], other_y[130:120], other_z[141:131], zero fill above
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_x[31:0], new_y[42:32], new_z[53:43], is_greater[54], zero fill above
	output logic [55:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_data
);
	import gimr_pkg::*;

	logic [EXT_W-1:0] y_extent_q;
	logic [EXT_W-1:0] z_extent_q;
	logic [EXT_W-1:0] y_ext;
	logic [EXT_W-1:0] z_ext;
	logic             adv;

	logic             valid_s1;
	logic [MAG_W-1:0] mag_s1;
	item_t            item_s1;

	logic             a_valid;
	logic [MAG_W-1:0] a_quot;
	logic [EXT_W-1:0] a_rem;
	item_t            a_item;
	mid_t             a_mid;

	logic             b_valid;
	logic [MAG_W-1:0] b_quot;
	logic [EXT_W-1:0] b_rem;
	mid_t             b_mid;

	logic [31:0]      new_x_q;
	logic [10:0]      new_y_q;
	logic [10:0]      new_z_q;
	logic             gt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_extent_q <= EXT_W'(2);
			z_extent_q <= EXT_W'(2);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_Y_EXTENT: y_extent_q <= cfg_data;
				REG_Z_EXTENT: z_extent_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective extents, held to the supported range.
	always_comb begin
		y_ext = y_extent_q;
		z_ext = z_extent_q;
		if (y_extent_q < EXT_W'(2)) y_ext = EXT_W'(2);
		else if (32'(y_extent_q) > 32'(MAX_EXTENT)) y_ext = EXT_W'(MAX_EXTENT);
		if (z_extent_q < EXT_W'(2)) z_ext = EXT_W'(2);
		else if (32'(z_extent_q) > 32'(MAX_EXTENT)) z_ext = EXT_W'(MAX_EXTENT);
	end

	// The pipeline moves whenever the output register is free or being drained.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	gimr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.operation (s_tdata[2:0]),
		.pos_x     (s_tdata[34:3]),
		.pos_y     (s_tdata[45:35]),
		.pos_z     (s_tdata[56:46]),
		.offset    (s_tdata[87:57]),
		.other_x   (s_tdata[119:88]),
		.other_y   (s_tdata[130:120]),
		.other_z   (s_tdata[141:131]),
		.y_ext     (y_ext),
		.z_ext     (z_ext),
		.valid_s1  (valid_s1),
		.mag_s1    (mag_s1),
		.item_s1   (item_s1)
	);

	// The offset magnitude divided by z gives the z digit as remainder.
	gimr_div #(
		.DW ($bits(mag_s1)),
		.SW ($bits(item_t))
	) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s1),
		.dividend  (mag_s1),
		.divisor   (z_ext),
		.side_in   (item_s1),
		.out_valid (a_valid),
		.quotient  (a_quot),
		.remainder (a_rem),
		.side_out  (a_item)
	);

	assign a_mid.it = a_item;
	assign a_mid.zd = a_rem;

	// That quotient divided by y gives the y digit and the x step.
	gimr_div #(
		.DW ($bits(a_quot)),
		.SW ($bits(mid_t))
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (a_valid),
		.dividend  (a_quot),
		.divisor   (y_ext),
		.side_in   (a_mid),
		.out_valid (b_valid),
		.quotient  (b_quot),
		.remainder (b_rem),
		.side_out  (b_mid)
	);

	gimr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (b_valid),
		.mid         (b_mid),
		.qx          (b_quot),
		.yd          (b_rem),
		.y_ext       (y_ext),
		.z_ext       (z_ext),
		.out_valid_q (m_tvalid),
		.new_x_q     (new_x_q),
		.new_y_q     (new_y_q),
		.new_z_q     (new_z_q),
		.gt_q        (gt_q)
	);

	assign m_tdata = {1'b0, gt_q, new_z_q, new_y_q, new_x_q};

endmodule

FILE: rtl/core/gimr_checker.sv
module gimr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [55:0]  m_tdata,
	input logic         cfg_ready
);

	// Input acceptance is tied to the output register being free or drained.
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind grid_index_mixed_radix_step_core gimr_checker u_gimr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);

FILE: tb/grid_index_mixed_radix_step_checker.sv
module grid_index_mixed_radix_step_checker #(
	parameter int MAX_EXTENT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [55:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_data,
	output int           mismatches,
	output int           outstanding
);
	import gimr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [X_W-1:0]   x;
		logic [EXT_W-1:0] y;
		logic [EXT_W-1:0] z;
		logic             gt;
	} position_t;

	position_t        expected_positions[$];
	logic [EXT_W-1:0] y_extent_reg;
	logic [EXT_W-1:0] z_extent_reg;

	function automatic int clamp_range(int v, int lo, int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Computes the result of one request under the given extents.
	function automatic position_t step_position(logic [143:0] d, logic [EXT_W-1:0] yreg,
			logic [EXT_W-1:0] zreg);
		logic [2:0]       op;
		logic [X_W-1:0]   px;
		logic [X_W-1:0]   ox;
		logic [EXT_W-1:0] py, pz, oy, oz;
		logic [OFF_W-1:0] off;
		logic [31:0]      mag;
		logic [X_W-1:0]   x;
		longint unsigned  plane, r;
		int               ye, ze, y, z;
		bit               neg, fwd;
		position_t        res;
		op  = d[2:0];
		px  = d[34:3];
		py  = d[45:35];
		pz  = d[56:46];
		off = d[87:57];
		ox  = d[119:88];
		oy  = d[130:120];
		oz  = d[141:131];
		ye  = clamp_range(int'(yreg), 2, MAX_EXTENT);
		ze  = clamp_range(int'(zreg), 2, MAX_EXTENT);
		y   = clamp_range(int'(py), 1, ye);
		z   = clamp_range(int'(pz), 1, ze);
		neg = off[OFF_W-1];
		mag = neg ? (32'h8000_0000 - {1'b0, off}) : {1'b0, off};
		res = '{x: px, y: py, z: pz, gt: 1'b0};
		if (op <= OP_DEC) begin
			if (op == OP_ADD) begin
				fwd = !neg;
			end else if (op == OP_SUB) begin
				fwd = neg;
			end else begin
				fwd = (op == OP_INC);
				mag = 32'd1;
			end
			plane = longint'(ye) * longint'(ze);
			r = mag % plane;
			x = px;
			// The z digit settles before the y digit in both directions.
			if (fwd) begin
				x = x + 32'(mag / plane);
				y = y + int'(r / ze);
				z = z + int'(r % ze);
				if (z > ze) begin
					y = y + 1;
					z = z - ze;
				end
				if (y > ye) begin
					x = x + 32'd1;
					y = y - ye;
				end
			end else begin
				x = x - 32'(mag / plane);
				y = y - int'(r / ze);
				z = z - int'(r % ze);
				if (z < 1) begin
					y = y - 1;
					z = z + ze;
				end
				if (y < 1) begin
					x = x - 32'd1;
					y = y + ye;
				end
			end
			res.x = x;
			res.y = EXT_W'(y);
			res.z = EXT_W'(z);
		end else if (op == OP_CMP) begin
			if ($signed(px) > $signed(ox)) begin
				res.gt = 1'b1;
			end else if (px == ox && py > oy) begin
				res.gt = 1'b1;
			end else if (px == ox && py == oy && pz > oz) begin
				res.gt = 1'b1;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		position_t want, got;
		if (!arst_n) begin
			y_extent_reg = 11'd2;
			z_extent_reg = 11'd2;
			expected_positions.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_Y_EXTENT) begin
					y_extent_reg = cfg_data;
				end else begin
					z_extent_reg = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_positions = {expected_positions,
					step_position(s_tdata, y_extent_reg, z_extent_reg)};
			end
			if (m_tvalid && m_tready) begin
				got = '{x: m_tdata[31:0], y: m_tdata[42:32], z: m_tdata[53:43], gt: m_tdata[54]};
				if (expected_positions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result x=%0d y=%0d z=%0d gt=%0b",
							$signed(got.x), got.y, got.z, got.gt);
					end
				end else begin
					want = expected_positions.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"mismatch: expected x=%0d y=%0d z=%0d gt=%0b,",
								" got x=%0d y=%0d z=%0d gt=%0b"},
								$signed(want.x), want.y, want.z, want.gt,
								$signed(got.x), got.y, got.z, got.gt);
						end
					end
				end
			end
			outstanding = expected_positions.size();
		end
	end

endmodule

FILE: tb/grid_index_mixed_radix_step_core_test.sv
module grid_index_mixed_radix_step_core_test;
	import gimr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// LATENCY is the time the block takes to present a result after its request is
	// taken; pauses allow a margin on top.
	localparam int LATENCY    = 63;
	localparam int WATCHDOG   = 4000;
	localparam int MAX_EXT    = 1024;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = 1'b0;
	logic [10:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int sink_hold = 0;

	// Extents as the block will use them, for shaping well-formed positions.
	int y_used = 2;
	int z_used = 2;

	always #4 clk = ~clk;

	grid_index_mixed_radix_step_core #(.MAX_EXTENT(MAX_EXT)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	grid_index_mixed_radix_step_checker #(.MAX_EXTENT(MAX_EXT)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
	);

	// The result side stalls in random bursts until the final phase.
	always @(posedge clk) begin
		if (!calm && sink_hold == 0 && $urandom_range(0, 9) == 0) begin
			sink_hold = $urandom_range(1, 7);
		end
		if (calm || sink_hold == 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			sink_hold--;
		end
	end

	// The watchdog counts cycles with no request, result or configuration write moving.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("grid_index_mixed_radix_step_core_test: done, errors");
			$finish;
		end
	end

	function automatic logic [143:0] pack_request(logic [2:0] op, logic [31:0] px,
			logic [10:0] py, logic [10:0] pz, logic [30:0] off, logic [31:0] ox,
			logic [10:0] oy, logic [10:0] oz);
		return {2'b00, oz, oy, ox, off, pz, py, px, op};
	endfunction

	// Sends one request and holds it until the block takes it. Valid stays high
	// into the next request unless an idle burst is drawn, so valid is never
	// lowered and raised within one step.
	task automatic send_request(logic [143:0] d);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(negedge clk);
		while (!s_tready) begin
			@(negedge clk);
		end
		@(posedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [10:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_extents(logic [10:0] ye, logic [10:0] ze);
		write_register(REG_Y_EXTENT, ye);
		write_register(REG_Z_EXTENT, ze);
		y_used = (ye < 2) ? 2 : (ye > MAX_EXT) ? MAX_EXT : ye;
		z_used = (ze < 2) ? 2 : (ze > MAX_EXT) ? MAX_EXT : ze;
	endtask

	// A coordinate that is mostly inside the grid, often on its edges, and
	// sometimes anywhere in the field so every bit toggles.
	function automatic logic [10:0] pick_coord(int ext);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return 11'($urandom_range(0, 2047));
		end else if (sel == 1) begin
			return 11'(ext);
		end else if (sel == 2) begin
			return 11'd1;
		end
		return 11'($urandom_range(1, ext));
	endfunction

	function automatic logic [30:0] pick_offset();
		int sel;
		int plane;
		sel = $urandom_range(0, 5);
		plane = y_used * z_used;
		case (sel)
			0: return 31'($urandom());
			1: return 31'($urandom_range(0, 2 * plane));
			2: return -31'($urandom_range(0, 2 * plane));
			3: return 31'($urandom_range(0, z_used + 1));
			4: return -31'($urandom_range(0, z_used + 1));
			default: return 31'($urandom_range(0, 1 << 20)) * 31'($urandom_range(1, 1000));
		endcase
	endfunction

	task automatic random_request();
		logic [2:0]  op;
		logic [31:0] px, ox;
		logic [10:0] py, pz, oy, oz;
		int          sel;
		sel = $urandom_range(0, 19);
		if (sel < 6) begin
			op = OP_ADD;
		end else if (sel < 10) begin
			op = OP_SUB;
		end else if (sel < 13) begin
			op = OP_INC;
		end else if (sel < 16) begin
			op = OP_DEC;
		end else if (sel < 19) begin
			op = OP_CMP;
		end else begin
			op = 3'(OP_CMP) + 3'($urandom_range(1, 3));
		end
		px = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 20)) - 32'd10;
		py = pick_coord(y_used);
		pz = pick_coord(z_used);
		// Compares often share the leading digits so the lower ones decide.
		ox = ($urandom_range(0, 1) == 0) ? px : $urandom();
		oy = ($urandom_range(0, 1) == 0) ? py : pick_coord(y_used);
		oz = ($urandom_range(0, 1) == 0) ? pz : 11'($urandom_range(0, 2047));
		send_request(pack_request(op, px, py, pz, pick_offset(), ox, oy, oz));
	endtask

	initial begin
		logic [31:0] x_max, x_min;
		x_max = 32'h7FFF_FFFF;
		x_min = 32'h8000_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks at the reset extents of two by two.
		send_request(pack_request(OP_ADD, 32'd1, 11'd1, 11'd1, 31'd0, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_ADD, x_max, 11'd2, 11'd2, 31'd1, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_SUB, x_min, 11'd1, 11'd1, 31'd1, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_ADD, 32'd5, 11'd1, 11'd2, 31'h3FFF_FFFF, '0, 11'd1, 11'd1));
		// The most negative offset has a magnitude of 2^30.
		send_request(pack_request(OP_ADD, 32'd0, 11'd1, 11'd1, 31'h4000_0000, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_SUB, 32'd0, 11'd1, 11'd1, 31'h4000_0000, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_SUB, 32'd3, 11'd2, 11'd1, -31'd3, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_INC, 32'd0, 11'd2, 11'd2, 31'd0, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_DEC, 32'd0, 11'd1, 11'd1, 31'd0, '0, 11'd1, 11'd1));
		// Coordinates outside the grid are pulled in before moving.
		send_request(pack_request(OP_INC, 32'd0, 11'd0, 11'h7FF, 31'd0, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_DEC, 32'd0, 11'h7FF, 11'd0, 31'd0, '0, 11'd1, 11'd1));
		// Compares take raw values with x signed.
		send_request(pack_request(OP_CMP, x_max, 11'h7FF, 11'h7FF, 31'h7FFF_FFFF, x_min, 11'd0,
			11'd0));
		send_request(pack_request(OP_CMP, x_min, 11'd0, 11'd0, 31'd0, x_max, 11'h7FF, 11'h7FF));
		send_request(pack_request(OP_CMP, 32'd4, 11'd3, 11'd9, 31'd0, 32'd4, 11'd3, 11'd9));
		send_request(pack_request(OP_CMP, 32'd4, 11'd3, 11'd9, 31'd0, 32'd4, 11'd3, 11'd8));
		send_request(pack_request(OP_CMP, 32'd4, 11'd4, 11'd1, 31'd0, 32'd4, 11'd3, 11'd9));
		// Undefined operations pass the position through.
		send_request(pack_request(3'(OP_CMP) + 3'd1, 32'd7, 11'h7FF, 11'd0, 31'd9, '0, 11'd0,
			11'd0));
		send_request(pack_request(3'(OP_CMP) + 3'd3, x_min, 11'd0, 11'h7FF, 31'd9, '0, 11'd0,
			11'd0));
		wait_drained();

		// Largest extents, including a write above the supported maximum.
		set_extents(11'd1024, 11'h7FF);
		send_request(pack_request(OP_ADD, 32'd0, 11'd1024, 11'd1024, 31'h3FFF_FFFF, '0, 11'd1,
			11'd1));
		send_request(pack_request(OP_SUB, 32'd0, 11'd1, 11'd1, 31'h3FFF_FFFF, '0, 11'd1, 11'd1));
		send_request(pack_request(OP_INC, 32'd0, 11'd1024, 11'd1024, 31'd0, '0, 11'd1, 11'd1));
		repeat (140) random_request();
		wait_drained();

		// Extents below two act as two.
		set_extents(11'd0, 11'd1);
		repeat (140) random_request();
		wait_drained();

		set_extents(11'd3, 11'd7);
		repeat (140) random_request();
		wait_drained();

		set_extents(11'd1000, 11'd2);
		repeat (140) random_request();
		wait_drained();

		set_extents(11'd2, 11'd1024);
		repeat (140) random_request();
		wait_drained();

		// Final phase runs without idling on either side.
		set_extents(11'd17, 11'd33);
		calm = 1'b1;
		repeat (150) random_request();
		wait_drained();

		if (mismatches == 0 && outstanding == 0) begin
			$display("grid_index_mixed_radix_step_core_test: done, clean");
		end else begin
			$display("grid_index_mixed_radix_step_core_test: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/gimr_pkg.sv
rtl/core/gimr_front.sv
rtl/core/gimr_div.sv
rtl/core/gimr_back.sv
rtl/core/grid_index_mixed_radix_step_core.sv
rtl/core/gimr_checker.sv
tb/grid_index_mixed_radix_step_checker.sv
tb/grid_index_mixed_radix_step_core_test.sv
